// File: design/bgd_pkg.sv
// ----------------------------------------------------------------------------
// bgd_pkg
// Shared types and constants for the button gesture detector.
// ----------------------------------------------------------------------------
`default_nettype none

package bgd_pkg;

    localparam int TIME_BITS = 32;

    localparam logic [3:0]  DEBOUNCE_RESET = 4'd3;
    localparam logic [15:0] HOLD_RESET     = 16'd1000;
    localparam logic [15:0] GAP_RESET      = 16'd500;

    typedef logic [TIME_BITS-1:0] t_time;

    typedef enum logic [1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_HOLD     = 2'd1,
        REG_GAP      = 2'd2
    } t_reg_index;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_DOUBLE = 2'd1,
        EV_LONG   = 2'd2
    } t_event;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_DOWN  = 5'b00010,
        PH_UP    = 5'b00100,
        PH_DOWN2 = 5'b01000,
        PH_LONG  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic        pin_level;
        logic [31:0] now_ms;
    } t_in;

    typedef struct packed {
        logic [1:0] gesture_event;
        logic       clean_level;
    } t_out;

    // debounced level after this sample and at the previous sample
    typedef struct packed {
        logic clean_now;
        logic clean_before;
    } t_level;

endpackage

`default_nettype wire

// File: design/bgd_debounce.sv
// ----------------------------------------------------------------------------
// bgd_debounce
// Counter debounce: the clean level follows the raw pin after a run of
// equal samples. Presents the next clean level and the current one.
// ----------------------------------------------------------------------------
`default_nettype none

module bgd_debounce
    import bgd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic       i_level,
    input  wire logic [3:0] i_need,
    output t_level          o_level
);

    logic [3:0] r_press_run, n_press_run;
    logic [3:0] r_release_run, n_release_run;
    logic       r_clean, n_clean;

    always_comb begin
        n_press_run   = r_press_run;
        n_release_run = r_release_run;
        n_clean       = r_clean;
        if (!i_level && (r_release_run < i_need)) begin
            n_press_run   = 4'd0;
            n_release_run = r_release_run + 4'd1;
            if (n_release_run == i_need) begin
                n_clean = 1'b0;
            end
        end
        if (i_level && (r_press_run < i_need)) begin
            n_release_run = 4'd0;
            n_press_run   = r_press_run + 4'd1;
            if (n_press_run == i_need) begin
                n_clean = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_run   <= 4'd0;
            r_release_run <= 4'd0;
            r_clean       <= 1'b0;
        end else if (i_en) begin
            r_press_run   <= n_press_run;
            r_release_run <= n_release_run;
            r_clean       <= n_clean;
        end
    end

    assign o_level.clean_now    = n_clean;
    assign o_level.clean_before = r_clean;

endmodule

`default_nettype wire

// File: design/bgd_gesture.sv
// ----------------------------------------------------------------------------
// bgd_gesture
// Gesture state machine: tracks clean edges and press/release time stamps,
// reports double tap and long press.
// ----------------------------------------------------------------------------
`default_nettype none

module bgd_gesture
    import bgd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire t_level      i_level,
    input  wire logic [31:0] i_now,
    input  wire logic [15:0] i_hold_ms,
    input  wire logic [15:0] i_gap_ms,
    output t_event           o_event
);

    t_phase r_phase, n_phase;
    t_time  r_press_stamp, n_press_stamp;
    t_time  r_release_stamp, n_release_stamp;
    t_time  now;
    t_time  held;
    t_time  gap;
    logic   rise;
    logic   fall;

    assign now  = TIME_BITS'(i_now);
    assign rise = i_level.clean_now && !i_level.clean_before;
    assign fall = !i_level.clean_now && i_level.clean_before;

    always_comb begin
        n_phase         = r_phase;
        n_press_stamp   = r_press_stamp;
        n_release_stamp = r_release_stamp;
        o_event         = EV_NONE;

        if (rise) begin
            n_press_stamp = now;
            case (r_phase)
                PH_IDLE: n_phase = PH_DOWN;
                PH_UP:   n_phase = PH_DOWN2;
                default: n_phase = r_phase;
            endcase
        end

        if (fall) begin
            n_release_stamp = now;
            case (r_phase)
                PH_DOWN:  n_phase = PH_UP;
                PH_DOWN2: begin
                    o_event = EV_DOUBLE;
                    n_phase = PH_IDLE;
                end
                PH_LONG:  n_phase = PH_IDLE;
                default:  n_phase = r_phase;
            endcase
        end

        // wrapping differences against the stamps as updated above
        held = now - n_press_stamp;
        gap  = now - n_release_stamp;

        if (i_level.clean_now) begin
            if ((held > TIME_BITS'(i_hold_ms)) && (n_phase != PH_LONG)) begin
                o_event = EV_LONG;
                n_phase = PH_LONG;
            end
        end else if (gap > TIME_BITS'(i_gap_ms)) begin
            n_phase = PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_press_stamp   <= '0;
            r_release_stamp <= '0;
        end else if (i_en) begin
            r_phase         <= n_phase;
            r_press_stamp   <= n_press_stamp;
            r_release_stamp <= n_release_stamp;
        end
    end

endmodule

`default_nettype wire

// File: design/button_gesture_detector_unit.sv
// An accepted request's result enters the output register in the next cycle.
// Throughput: one request per cycle; the output register takes a new result in
// the cycle its current one is taken, so the input stalls only while the
// output side stalls.
// Reset: synchronous, active low; clears debounce counters, gesture phase,
// time stamps and the output valid, and loads register reset values.
// ----------------------------------------------------------------------------
// button_gesture_detector_unit
// Debounced button with double-tap and long-press detection, one poll per
// request, with a configuration write port.
// ----------------------------------------------------------------------------
`default_nettype none

module button_gesture_detector_unit
    import bgd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in         i_in_data,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out             o_out_data,
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    logic [3:0]  r_debounce_count;
    logic [15:0] r_hold_ms;
    logic [15:0] r_gap_ms;
    logic [3:0]  need;
    logic        accept;
    t_level      level;
    t_event      gesture_event;
    logic        r_out_valid;
    t_out        r_out_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_count <= DEBOUNCE_RESET;
            r_hold_ms        <= HOLD_RESET;
            r_gap_ms         <= GAP_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_DEBOUNCE: r_debounce_count <= i_cfg_data[3:0];
                REG_HOLD:     r_hold_ms        <= i_cfg_data;
                REG_GAP:      r_gap_ms         <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // a zero count behaves as one
    assign need = (r_debounce_count == 4'd0) ? 4'd1 : r_debounce_count;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    bgd_debounce u_debounce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept),
        .i_level (i_in_data.pin_level),
        .i_need  (need),
        .o_level (level)
    );

    bgd_gesture u_gesture (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (accept),
        .i_level   (level),
        .i_now     (i_in_data.now_ms),
        .i_hold_ms (r_hold_ms),
        .i_gap_ms  (r_gap_ms),
        .o_event   (gesture_event)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data.gesture_event <= gesture_event;
            r_out_data.clean_level   <= level.clean_now;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// File: design/bgd_checker.sv
// ----------------------------------------------------------------------------
// bgd_checker
// Port-level checks for the button gesture detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bgd_checker
    import bgd_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_ready,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire t_out o_out_data
);

    // every accepted request leaves a result in the output register
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("accepted request produced no result");

    // an empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output register");

    // a stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    // a double tap is reported on a release, a long press while held
    a_double_on_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.gesture_event == EV_DOUBLE))
            |-> !o_out_data.clean_level)
        else $error("double tap reported while pressed");

    a_long_while_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.gesture_event == EV_LONG))
            |-> o_out_data.clean_level)
        else $error("long press reported while released");

endmodule

bind button_gesture_detector_unit bgd_checker u_bgd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
